// ===== sv/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
`default_nettype none
package bcc_pkg;

   localparam int MAX_BUTTONS = 8;
   localparam int IDX_W       = $clog2(MAX_BUTTONS);
   localparam int CNT_W       = 4;
   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;
   localparam int EV_W        = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 16;

   localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EV_W-1:0] EV_PRESS        = 3'd1;
   localparam logic [EV_W-1:0] EV_CLICK        = 3'd2;
   localparam logic [EV_W-1:0] EV_DOUBLE       = 3'd3;
   localparam logic [EV_W-1:0] EV_LONG         = 3'd4;
   localparam logic [EV_W-1:0] EV_HELD         = 3'd5;
   localparam logic [EV_W-1:0] EV_HELD_RELEASE = 3'd6;

   localparam logic CMD_POLL = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CLICK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_GAP    = 3'd4;

   localparam logic [CNT_W-1:0] RST_BUTTON_COUNT = 4'd8;
   localparam logic [MS_W-1:0]  RST_DEBOUNCE     = 16'd50;
   localparam logic [MS_W-1:0]  RST_LONG_CLICK   = 16'd500;
   localparam logic [MS_W-1:0]  RST_HOLD_TIMEOUT = 16'd1000;
   localparam logic [MS_W-1:0]  RST_MULTI_GAP    = 16'd225;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_AGE,
      ST_IRQ,
      ST_HANDLE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic read_step;
      logic age_step;
      logic irq_step;
      logic handle_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic age_last;
      logic irq_fire;
      logic pin_found;
      logic out_busy;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/bcc_ctrl.sv =====
// Sequencer for poll and read items of the button click classifier.
`default_nettype none
module bcc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             rsp_tready,
   input  wire bcc_pkg::sts_type sts,
   output bcc_pkg::cmd_type      cmd
);

   bcc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.is_read ? bcc_pkg::ST_READ : bcc_pkg::ST_AGE;
            end
         end
         bcc_pkg::ST_READ: begin
            state_in = bcc_pkg::ST_DONE;
         end
         bcc_pkg::ST_AGE: begin
            if (sts.age_last) begin
               state_in = bcc_pkg::ST_IRQ;
            end
         end
         bcc_pkg::ST_IRQ: begin
            state_in = (sts.irq_fire && sts.pin_found) ? bcc_pkg::ST_HANDLE
                                                       : bcc_pkg::ST_DONE;
         end
         bcc_pkg::ST_HANDLE: begin
            state_in = bcc_pkg::ST_DONE;
         end
         bcc_pkg::ST_DONE: begin
            if (!sts.out_busy || rsp_tready) begin
               state_in = bcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         bcc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bcc_pkg::ST_READ: begin
            cmd.read_step = 1'b1;
         end
         bcc_pkg::ST_AGE: begin
            cmd.age_step = 1'b1;
         end
         bcc_pkg::ST_IRQ: begin
            cmd.irq_step = 1'b1;
         end
         bcc_pkg::ST_HANDLE: begin
            cmd.handle_step = 1'b1;
         end
         bcc_pkg::ST_DONE: begin
            cmd.out_load = !sts.out_busy || rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/bcc_dp.sv =====
// Datapath: settings, per-button state, aging and pin rules, result register.
`default_nettype none
module bcc_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tuser,
   input  wire logic [bcc_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [bcc_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [bcc_pkg::MS_W-1:0]             csr_wdata,
   input  wire bcc_pkg::cmd_type                     cmd,
   output bcc_pkg::sts_type                          sts
);

   localparam int NB = bcc_pkg::MAX_BUTTONS;
   localparam int TW = bcc_pkg::TIME_W;
   localparam int IW = bcc_pkg::IDX_W;
   localparam int EW = bcc_pkg::EV_W;

   logic [bcc_pkg::CNT_W-1:0] button_count_ff;
   logic [bcc_pkg::MS_W-1:0]  debounce_ff, long_click_ff, hold_timeout_ff, multi_gap_ff;

   logic [TW-1:0]   now_ff;
   logic [NB-1:0]   flags_ff, capture_ff;
   logic [IW-1:0]   idx_ff;
   logic [TW-1:0]   gap_ff;
   logic [TW-1:0]   last_irq_ff;
   logic            irq_pending_ff;

   logic            pressed_ff   [NB];
   logic [1:0]      rc_ff        [NB];
   logic [TW-1:0]   press_ff     [NB];
   logic [TW-1:0]   release_ff   [NB];
   logic [EW-1:0]   event_ff     [NB];
   logic [NB-1:0]   needs_ff;

   logic [EW-1:0]   code_ff;
   logic            fresh_ff, nopin_ff;
   logic            rsp_valid_ff;

   logic [bcc_pkg::CNT_W-1:0] active_n;
   logic [NB-1:0]   active_mask;
   logic [NB-1:0]   cand;
   logic [IW-1:0]   pin;
   logic            pin_found;
   logic [TW-1:0]   irq_gap;
   logic            irq_fire;

   logic [TW-1:0]   rel_gap, held_for;
   logic            click_due, hold_over;
   logic            we;
   logic            pressed_n;
   logic [1:0]      rc_n;
   logic [TW-1:0]   press_n, release_n;
   logic [EW-1:0]   event_n;
   logic            needs_n;
   logic [EW-1:0]   ev_mid;
   logic            idx_active;

   assign active_n = (button_count_ff > bcc_pkg::CNT_W'(NB)) ? bcc_pkg::CNT_W'(NB)
                                                              : button_count_ff;
   assign idx_active = {1'b0, idx_ff} < active_n;

   always_comb begin
      for (int i = 0; i < NB; i++) begin
         active_mask[i] = bcc_pkg::CNT_W'(i) < active_n;
      end
      cand      = flags_ff & active_mask;
      pin       = '0;
      pin_found = 1'b0;
      for (int i = NB - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pin       = IW'(i);
            pin_found = 1'b1;
         end
      end
   end

   assign irq_gap  = now_ff - last_irq_ff;
   assign irq_fire = irq_pending_ff && (irq_gap >= {{(TW-bcc_pkg::MS_W){1'b0}}, debounce_ff});

   assign rel_gap   = now_ff - release_ff[idx_ff];
   assign held_for  = now_ff - press_ff[idx_ff];
   assign click_due = rel_gap >= {{(TW-bcc_pkg::MS_W){1'b0}}, multi_gap_ff};
   assign hold_over = held_for > {{(TW-bcc_pkg::MS_W){1'b0}}, hold_timeout_ff};

   always_comb begin
      we        = 1'b0;
      pressed_n = pressed_ff[idx_ff];
      rc_n      = rc_ff[idx_ff];
      press_n   = press_ff[idx_ff];
      release_n = release_ff[idx_ff];
      event_n   = event_ff[idx_ff];
      needs_n   = needs_ff[idx_ff];
      ev_mid    = event_ff[idx_ff];
      if (cmd.read_step) begin
         we      = 1'b1;
         needs_n = 1'b0;
      end else if (cmd.age_step && idx_active) begin
         we = 1'b1;
         if (click_due && rc_ff[idx_ff] >= 2'd2) begin
            ev_mid  = bcc_pkg::EV_DOUBLE;
            needs_n = 1'b1;
            rc_n    = 2'd0;
         end else if (click_due && rc_ff[idx_ff] == 2'd1) begin
            ev_mid  = bcc_pkg::EV_CLICK;
            needs_n = 1'b1;
            rc_n    = 2'd0;
         end
         event_n = ev_mid;
         if (hold_over && pressed_ff[idx_ff] && ev_mid != bcc_pkg::EV_HELD) begin
            event_n = bcc_pkg::EV_HELD;
            needs_n = 1'b1;
         end
      end else if (cmd.handle_step) begin
         we        = 1'b1;
         pressed_n = capture_ff[idx_ff];
         if (capture_ff[idx_ff]) begin
            event_n = bcc_pkg::EV_PRESS;
            needs_n = 1'b1;
            press_n = now_ff;
         end else begin
            if (gap_ff < {{(TW-bcc_pkg::MS_W){1'b0}}, long_click_ff}) begin
               if (rc_ff[idx_ff] != 2'd3) begin
                  rc_n = rc_ff[idx_ff] + 2'd1;
               end
            end else if (gap_ff > {{(TW-bcc_pkg::MS_W){1'b0}}, long_click_ff}
                         && !hold_over) begin
               event_n = bcc_pkg::EV_LONG;
               needs_n = 1'b1;
            end
            if (hold_over && event_ff[idx_ff] == bcc_pkg::EV_HELD) begin
               event_n = bcc_pkg::EV_HELD_RELEASE;
               needs_n = 1'b1;
            end
            press_n   = '0;
            release_n = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) begin
            pressed_ff[i] <= 1'b0;
            rc_ff[i]      <= '0;
            press_ff[i]   <= '0;
            release_ff[i] <= '0;
            event_ff[i]   <= bcc_pkg::EV_NONE;
         end
         needs_ff <= '0;
      end else if (we) begin
         pressed_ff[idx_ff] <= pressed_n;
         rc_ff[idx_ff]      <= rc_n;
         press_ff[idx_ff]   <= press_n;
         release_ff[idx_ff] <= release_n;
         event_ff[idx_ff]   <= event_n;
         needs_ff[idx_ff]   <= needs_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_count_ff <= bcc_pkg::RST_BUTTON_COUNT;
         debounce_ff     <= bcc_pkg::RST_DEBOUNCE;
         long_click_ff   <= bcc_pkg::RST_LONG_CLICK;
         hold_timeout_ff <= bcc_pkg::RST_HOLD_TIMEOUT;
         multi_gap_ff    <= bcc_pkg::RST_MULTI_GAP;
      end else if (csr_we) begin
         unique case (csr_index)
            bcc_pkg::CSR_BUTTON_COUNT: button_count_ff <= csr_wdata[bcc_pkg::CNT_W-1:0];
            bcc_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
            bcc_pkg::CSR_LONG_CLICK:   long_click_ff   <= csr_wdata;
            bcc_pkg::CSR_HOLD_TIMEOUT: hold_timeout_ff <= csr_wdata;
            bcc_pkg::CSR_MULTI_GAP:    multi_gap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_pending_ff <= 1'b0;
         last_irq_ff    <= '0;
         idx_ff         <= '0;
         nopin_ff       <= 1'b0;
         code_ff        <= bcc_pkg::EV_NONE;
         fresh_ff       <= 1'b0;
      end else begin
         if (cmd.load) begin
            now_ff     <= req_tdata[31:0];
            flags_ff   <= req_tdata[40:33];
            capture_ff <= req_tdata[48:41];
            nopin_ff   <= 1'b0;
            code_ff    <= bcc_pkg::EV_NONE;
            fresh_ff   <= 1'b0;
            if (req_tuser == bcc_pkg::CMD_READ) begin
               idx_ff <= req_tdata[51:49];
            end else begin
               idx_ff <= '0;
               if (req_tdata[32]) begin
                  irq_pending_ff <= 1'b1;
               end
            end
         end
         if (cmd.read_step) begin
            code_ff  <= event_ff[idx_ff];
            fresh_ff <= needs_ff[idx_ff];
         end
         if (cmd.age_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.irq_step && irq_fire) begin
            irq_pending_ff <= 1'b0;
            last_irq_ff    <= now_ff;
            gap_ff         <= irq_gap;
            idx_ff         <= pin;
            nopin_ff       <= !pin_found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata <= {3'b000, nopin_ff, needs_ff, fresh_ff, code_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   assign sts.is_read   = req_tuser == bcc_pkg::CMD_READ;
   assign sts.age_last  = ({1'b0, idx_ff} + bcc_pkg::CNT_W'(1)) >= active_n;
   assign sts.irq_fire  = irq_fire;
   assign sts.pin_found = pin_found;
   assign sts.out_busy  = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/button_click_classifier_unit.sv =====
// Top level of the button click classifier.
// A poll item (tuser 0) ages each button in use, one button a cycle, then
// takes at most one debounced interrupt and applies the press or release
// rules to the lowest flagged pin. A poll's length grows with the number
// of buttons in use, through the per-button aging walk. A read item
// (tuser 1) returns one button's event code and new-event bit and clears
// that bit. Every item gives exactly one result. The next item is taken
// while a result still waits on the rsp side; an item holds in its last
// cycle while an earlier result still waits. Settings must be written
// through the csr port while idle; the block itself does not enforce this.
`default_nettype none
module button_click_classifier_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // now_ms[31:0], irq_event[32], irq_flags[40:33], capture_bits[48:41],
   // button_id[51:49], zero fill
   input  wire logic [bcc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command[0]
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // event_code[2:0], new_event[3], pending_mask[11:4], no_pin_error[12]
   output logic [bcc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bcc_pkg::MS_W-1:0]           csr_wdata
);

   bcc_pkg::cmd_type cmd;
   bcc_pkg::sts_type sts;

   bcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bcc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire
